/* sv/cbc_pkg.sv */
// shared widths, codes and types for the circle/box collision pipeline
package cbc_pkg;

    localparam int POS_W  = 32;
    localparam int SIZE_W = 31;
    localparam int DIFF_W = 33;
    localparam int OVL_W  = 34;
    localparam int VEC_W  = 34;
    localparam int SUM_W  = 68;
    localparam int ROOT_W = 34;
    localparam int REM_W  = ROOT_W + 3;
    localparam int RVAL_W = 33;
    localparam int Q_W    = 15;
    localparam int DN_W   = VEC_W + Q_W + 1;
    localparam int NORM_W = 16;
    localparam int PEN_W  = 32;

    localparam logic [1:0] KIND_CIRCLE = 2'd1;
    localparam logic [1:0] KIND_BOX    = 2'd2;

    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_CC   = 2'd1;
    localparam logic [1:0] MODE_BC   = 2'd2;
    localparam logic [1:0] MODE_BB   = 2'd3;

    localparam logic [2:0] NS_CALC = 3'd0;
    localparam logic [2:0] NS_POSX = 3'd1;
    localparam logic [2:0] NS_NEGX = 3'd2;
    localparam logic [2:0] NS_POSY = 3'd3;
    localparam logic [2:0] NS_NEGY = 3'd4;

    localparam logic [1:0] CHK_PRE = 2'd0;
    localparam logic [1:0] CHK_GE  = 2'd1;
    localparam logic [1:0] CHK_LT  = 2'd2;

    localparam logic [NORM_W-1:0] ONE_Q14     = 16'h4000;
    localparam logic [NORM_W-1:0] NEG_ONE_Q14 = 16'hC000;

    typedef struct packed {
        logic              hit;
        logic              swapped;
        logic [2:0]        nsel;
        logic              sx;
        logic              sy;
        logic [RVAL_W-1:0] rval;
    } side_t;

endpackage

/* sv/cbc_front.sv */
// front stages: dispatch, offsets, clamp and overlap, squares and hit test
module cbc_front import cbc_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               a_kind,
    input  logic [1:0]               b_kind,
    input  logic                     same_entity,
    input  logic signed [POS_W-1:0]  a_pos_x,
    input  logic signed [POS_W-1:0]  a_pos_y,
    input  logic signed [POS_W-1:0]  b_pos_x,
    input  logic signed [POS_W-1:0]  b_pos_y,
    input  logic [SIZE_W-1:0]        a_size_x,
    input  logic [SIZE_W-1:0]        a_size_y,
    input  logic [SIZE_W-1:0]        b_size_x,
    input  logic [SIZE_W-1:0]        b_size_y,
    output logic                     vld,
    output side_t                    side,
    output logic [VEC_W-1:0]         vx,
    output logic [VEC_W-1:0]         vy,
    output logic [SUM_W-1:0]         sum,
    input  logic                     rdy_dn
);

    logic en1, en2, en3, en4, en5, en6;

    // stage 1
    logic                s1_v_reg;
    logic [1:0]          s1_mode_reg;
    logic                s1_swp_reg;
    logic [DIFF_W-1:0]   s1_dx_reg, s1_dy_reg;
    logic [SIZE_W-1:0]   s1_hx_reg, s1_hy_reg, s1_r_reg, s1_ra_reg;
    logic [SIZE_W:0]     s1_hsx_reg, s1_hsy_reg;
    logic [1:0]          mode_next;
    logic                swp_next;
    logic [POS_W-1:0]    fx, fy, sx_pos, sy_pos;

    // stage 2
    logic                s2_v_reg;
    logic [1:0]          s2_mode_reg;
    logic                s2_swp_reg;
    logic [DIFF_W-1:0]   s2_adx_reg, s2_ady_reg;
    logic                s2_dxn_reg, s2_dyn_reg;
    logic [SIZE_W-1:0]   s2_hx_reg, s2_hy_reg, s2_r_reg, s2_ra_reg;
    logic [SIZE_W:0]     s2_hsx_reg, s2_hsy_reg;

    // stage 3
    logic                s3_v_reg;
    logic [1:0]          s3_mode_reg;
    logic                s3_swp_reg;
    logic [DIFF_W-1:0]   s3_adx_reg, s3_ady_reg;
    logic                s3_dxn_reg, s3_dyn_reg;
    logic [OVL_W-1:0]    s3_ex_reg, s3_ey_reg, s3_ox_reg, s3_oy_reg;
    logic                s3_zero_reg;
    logic [SIZE_W-1:0]   s3_r_reg, s3_ra_reg;
    logic [SIZE_W:0]     s3_hsx_reg;

    // stage 4
    logic                s4_v_reg;
    logic                s4_swp_reg;
    logic [VEC_W-1:0]    s4_vx_reg, s4_vy_reg;
    logic                s4_sx_reg, s4_sy_reg;
    logic [RVAL_W-1:0]   s4_rval_reg;
    logic [2:0]          s4_nsel_reg;
    logic [1:0]          s4_chk_reg;
    logic                s4_pre_reg;
    logic [SIZE_W:0]     s4_thr_reg;
    logic [VEC_W-1:0]    vx_next, vy_next;
    logic                sx_next, sy_next, pre_next, ex_le0, ey_le0, in_box;
    logic [RVAL_W-1:0]   rval_next;
    logic [2:0]          nsel_next;
    logic [1:0]          chk_next;
    logic [SIZE_W:0]     thr_next;

    // stage 5
    logic                s5_v_reg;
    logic                s5_swp_reg;
    logic [VEC_W-1:0]    s5_vx_reg, s5_vy_reg;
    logic                s5_sx_reg, s5_sy_reg;
    logic [RVAL_W-1:0]   s5_rval_reg;
    logic [2:0]          s5_nsel_reg;
    logic [1:0]          s5_chk_reg;
    logic                s5_pre_reg;
    logic [SUM_W-1:0]    s5_sqx_reg, s5_sqy_reg;
    logic [2*POS_W-1:0]  s5_thr2_reg;

    // stage 6
    logic                s6_v_reg;
    side_t               s6_side_reg;
    logic [VEC_W-1:0]    s6_vx_reg, s6_vy_reg;
    logic [SUM_W-1:0]    s6_sum_reg;
    logic [SUM_W-1:0]    sum_next, thr2_ext;
    logic                hit_next;

    assign en6 = !s6_v_reg || rdy_dn;
    assign en5 = !s5_v_reg || en6;
    assign en4 = !s4_v_reg || en5;
    assign en3 = !s3_v_reg || en4;
    assign en2 = !s2_v_reg || en3;
    assign en1 = !s1_v_reg || en2;
    assign in_ready = en1;

    always_comb
    begin
        swp_next  = 1'b0;
        mode_next = MODE_NONE;
        if (!same_entity)
        begin
            if (a_kind == KIND_CIRCLE && b_kind == KIND_CIRCLE)
                mode_next = MODE_CC;
            else if (a_kind == KIND_CIRCLE && b_kind == KIND_BOX)
            begin
                mode_next = MODE_BC;
                swp_next  = 1'b1;
            end
            else if (a_kind == KIND_BOX && b_kind == KIND_BOX)
                mode_next = MODE_BB;
            else if (a_kind == KIND_BOX && b_kind == KIND_CIRCLE)
                mode_next = MODE_BC;
        end
    end

    assign fx     = swp_next ? b_pos_x : a_pos_x;
    assign fy     = swp_next ? b_pos_y : a_pos_y;
    assign sx_pos = swp_next ? a_pos_x : b_pos_x;
    assign sy_pos = swp_next ? a_pos_y : b_pos_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
            s5_v_reg <= 1'b0;
            s6_v_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                s1_v_reg <= in_valid;
            if (en2)
                s2_v_reg <= s1_v_reg;
            if (en3)
                s3_v_reg <= s2_v_reg;
            if (en4)
                s4_v_reg <= s3_v_reg;
            if (en5)
                s5_v_reg <= s4_v_reg;
            if (en6)
                s6_v_reg <= s5_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_mode_reg <= mode_next;
            s1_swp_reg  <= swp_next;
            s1_dx_reg   <= {sx_pos[POS_W-1], sx_pos} - {fx[POS_W-1], fx};
            s1_dy_reg   <= {sy_pos[POS_W-1], sy_pos} - {fy[POS_W-1], fy};
            s1_hx_reg   <= swp_next ? b_size_x : a_size_x;
            s1_hy_reg   <= swp_next ? b_size_y : a_size_y;
            s1_r_reg    <= swp_next ? a_size_x : b_size_x;
            s1_ra_reg   <= a_size_x;
            s1_hsx_reg  <= {1'b0, a_size_x} + {1'b0, b_size_x};
            s1_hsy_reg  <= {1'b0, a_size_y} + {1'b0, b_size_y};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_mode_reg <= s1_mode_reg;
            s2_swp_reg  <= s1_swp_reg;
            s2_adx_reg  <= s1_dx_reg[DIFF_W-1] ? (DIFF_W'(0) - s1_dx_reg) : s1_dx_reg;
            s2_ady_reg  <= s1_dy_reg[DIFF_W-1] ? (DIFF_W'(0) - s1_dy_reg) : s1_dy_reg;
            s2_dxn_reg  <= s1_dx_reg[DIFF_W-1];
            s2_dyn_reg  <= s1_dy_reg[DIFF_W-1];
            s2_hx_reg   <= s1_hx_reg;
            s2_hy_reg   <= s1_hy_reg;
            s2_r_reg    <= s1_r_reg;
            s2_ra_reg   <= s1_ra_reg;
            s2_hsx_reg  <= s1_hsx_reg;
            s2_hsy_reg  <= s1_hsy_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            s3_mode_reg <= s2_mode_reg;
            s3_swp_reg  <= s2_swp_reg;
            s3_adx_reg  <= s2_adx_reg;
            s3_ady_reg  <= s2_ady_reg;
            s3_dxn_reg  <= s2_dxn_reg;
            s3_dyn_reg  <= s2_dyn_reg;
            s3_ex_reg   <= {1'b0, s2_adx_reg} - {3'b000, s2_hx_reg};
            s3_ey_reg   <= {1'b0, s2_ady_reg} - {3'b000, s2_hy_reg};
            s3_ox_reg   <= {2'b00, s2_hsx_reg} - {1'b0, s2_adx_reg};
            s3_oy_reg   <= {2'b00, s2_hsy_reg} - {1'b0, s2_ady_reg};
            s3_zero_reg <= (s2_adx_reg == '0) && (s2_ady_reg == '0);
            s3_r_reg    <= s2_r_reg;
            s3_ra_reg   <= s2_ra_reg;
            s3_hsx_reg  <= s2_hsx_reg;
        end
    end

    assign ex_le0 = s3_ex_reg[OVL_W-1] || (s3_ex_reg == '0);
    assign ey_le0 = s3_ey_reg[OVL_W-1] || (s3_ey_reg == '0);
    assign in_box = ex_le0 && ey_le0;

    always_comb
    begin
        vx_next   = '0;
        vy_next   = '0;
        sx_next   = s3_dxn_reg;
        sy_next   = s3_dyn_reg;
        rval_next = '0;
        nsel_next = NS_CALC;
        chk_next  = CHK_PRE;
        pre_next  = 1'b0;
        thr_next  = '0;
        case (s3_mode_reg)
            MODE_CC:
            begin
                vx_next   = {1'b0, s3_adx_reg};
                vy_next   = {1'b0, s3_ady_reg};
                rval_next = s3_zero_reg ? {2'b00, s3_ra_reg} : {1'b0, s3_hsx_reg};
                nsel_next = s3_zero_reg ? NS_POSX : NS_CALC;
                chk_next  = CHK_GE;
                thr_next  = s3_hsx_reg;
            end
            MODE_BB:
            begin
                pre_next = !s3_ox_reg[OVL_W-1] && !s3_oy_reg[OVL_W-1];
                if ($signed(s3_oy_reg) < $signed(s3_ox_reg))
                begin
                    nsel_next = s3_dyn_reg ? NS_NEGY : NS_POSY;
                    rval_next = s3_oy_reg[RVAL_W-1:0];
                end
                else
                begin
                    nsel_next = s3_dxn_reg ? NS_NEGX : NS_POSX;
                    rval_next = s3_ox_reg[RVAL_W-1:0];
                end
            end
            MODE_BC:
            begin
                thr_next  = {1'b0, s3_r_reg};
                rval_next = {2'b00, s3_r_reg};
                if (in_box)
                begin
                    // snap to the nearest edge, normal flipped back to the sign of the offset
                    pre_next = 1'b1;
                    if ($signed(s3_ey_reg) < $signed(s3_ex_reg))
                        vx_next = OVL_W'(0) - s3_ex_reg;
                    else
                        vy_next = OVL_W'(0) - s3_ey_reg;
                end
                else
                begin
                    chk_next = CHK_LT;
                    if (!ex_le0)
                        vx_next = s3_ex_reg;
                    if (!ey_le0)
                        vy_next = s3_ey_reg;
                end
            end
            default:
            begin
                pre_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            s4_swp_reg  <= s3_swp_reg;
            s4_vx_reg   <= vx_next;
            s4_vy_reg   <= vy_next;
            s4_sx_reg   <= sx_next;
            s4_sy_reg   <= sy_next;
            s4_rval_reg <= rval_next;
            s4_nsel_reg <= nsel_next;
            s4_chk_reg  <= chk_next;
            s4_pre_reg  <= pre_next;
            s4_thr_reg  <= thr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            s5_swp_reg  <= s4_swp_reg;
            s5_vx_reg   <= s4_vx_reg;
            s5_vy_reg   <= s4_vy_reg;
            s5_sx_reg   <= s4_sx_reg;
            s5_sy_reg   <= s4_sy_reg;
            s5_rval_reg <= s4_rval_reg;
            s5_nsel_reg <= s4_nsel_reg;
            s5_chk_reg  <= s4_chk_reg;
            s5_pre_reg  <= s4_pre_reg;
            s5_sqx_reg  <= s4_vx_reg * s4_vx_reg;
            s5_sqy_reg  <= s4_vy_reg * s4_vy_reg;
            s5_thr2_reg <= s4_thr_reg * s4_thr_reg;
        end
    end

    assign sum_next = s5_sqx_reg + s5_sqy_reg;
    assign thr2_ext = {4'b0000, s5_thr2_reg};

    always_comb
    begin
        case (s5_chk_reg)
            CHK_GE:  hit_next = thr2_ext >= sum_next;
            CHK_LT:  hit_next = sum_next < thr2_ext;
            default: hit_next = s5_pre_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en6)
        begin
            s6_side_reg.hit     <= hit_next;
            s6_side_reg.swapped <= s5_swp_reg;
            s6_side_reg.nsel    <= s5_nsel_reg;
            s6_side_reg.sx      <= s5_sx_reg;
            s6_side_reg.sy      <= s5_sy_reg;
            s6_side_reg.rval    <= s5_rval_reg;
            s6_vx_reg           <= s5_vx_reg;
            s6_vy_reg           <= s5_vy_reg;
            s6_sum_reg          <= sum_next;
        end
    end

    assign vld  = s6_v_reg;
    assign side = s6_side_reg;
    assign vx   = s6_vx_reg;
    assign vy   = s6_vy_reg;
    assign sum  = s6_sum_reg;

endmodule

/* sv/cbc_sqrt.sv */
// pipelined integer square root, one result bit per stage
module cbc_sqrt import cbc_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_vld,
    output logic              in_rdy,
    input  side_t             in_side,
    input  logic [VEC_W-1:0]  in_vx,
    input  logic [VEC_W-1:0]  in_vy,
    input  logic [SUM_W-1:0]  in_sum,
    output logic              vld,
    output side_t             side,
    output logic [VEC_W-1:0]  vx,
    output logic [VEC_W-1:0]  vy,
    output logic [ROOT_W-1:0] mag,
    input  logic              rdy_dn
);

    logic              v_reg    [0:ROOT_W-1];
    side_t             side_reg [0:ROOT_W-1];
    logic [VEC_W-1:0]  vx_reg   [0:ROOT_W-1];
    logic [VEC_W-1:0]  vy_reg   [0:ROOT_W-1];
    logic [SUM_W-1:0]  rad_reg  [0:ROOT_W-1];
    logic [REM_W-1:0]  rem_reg  [0:ROOT_W-1];
    logic [ROOT_W-1:0] root_reg [0:ROOT_W-1];
    logic [ROOT_W:0]   en;

    assign en[ROOT_W] = rdy_dn;
    assign in_rdy     = en[0];

    genvar k;
    generate
        for (k = 0; k < ROOT_W; k++)
        begin : g_stage
            logic              p_v;
            side_t             p_side;
            logic [VEC_W-1:0]  p_vx, p_vy;
            logic [SUM_W-1:0]  p_rad;
            logic [REM_W-1:0]  p_rem;
            logic [ROOT_W-1:0] p_root;
            logic [REM_W-1:0]  rem_sh, trial, rem_next;
            logic              ge;

            if (k == 0)
            begin : g_first
                assign p_v    = in_vld;
                assign p_side = in_side;
                assign p_vx   = in_vx;
                assign p_vy   = in_vy;
                assign p_rad  = in_sum;
                assign p_rem  = '0;
                assign p_root = '0;
            end
            else
            begin : g_next
                assign p_v    = v_reg[k-1];
                assign p_side = side_reg[k-1];
                assign p_vx   = vx_reg[k-1];
                assign p_vy   = vy_reg[k-1];
                assign p_rad  = rad_reg[k-1];
                assign p_rem  = rem_reg[k-1];
                assign p_root = root_reg[k-1];
            end

            assign en[k]    = !v_reg[k] || en[k+1];
            assign rem_sh   = {p_rem[REM_W-3:0], p_rad[SUM_W-1 -: 2]};
            assign trial    = REM_W'({p_root, 2'b01});
            assign ge       = rem_sh >= trial;
            assign rem_next = ge ? (rem_sh - trial) : rem_sh;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[k] <= 1'b0;
                else if (en[k])
                    v_reg[k] <= p_v;
            end

            always_ff @(posedge clk)
            begin
                if (en[k])
                begin
                    side_reg[k] <= p_side;
                    vx_reg[k]   <= p_vx;
                    vy_reg[k]   <= p_vy;
                    rad_reg[k]  <= {p_rad[SUM_W-3:0], 2'b00};
                    rem_reg[k]  <= rem_next;
                    root_reg[k] <= {p_root[ROOT_W-2:0], ge};
                end
            end
        end
    endgenerate

    assign vld  = v_reg[ROOT_W-1];
    assign side = side_reg[ROOT_W-1];
    assign vx   = vx_reg[ROOT_W-1];
    assign vy   = vy_reg[ROOT_W-1];
    assign mag  = root_reg[ROOT_W-1];

endmodule

/* sv/cbc_div.sv */
// pipelined rounding divide of both components by the magnitude, one quotient bit per stage after the first
module cbc_div import cbc_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_vld,
    output logic              in_rdy,
    input  side_t             in_side,
    input  logic [VEC_W-1:0]  in_vx,
    input  logic [VEC_W-1:0]  in_vy,
    input  logic [ROOT_W-1:0] in_mag,
    output logic              vld,
    output side_t             side,
    output logic [ROOT_W-1:0] mag,
    output logic [Q_W-1:0]    qx,
    output logic [Q_W-1:0]    qy,
    input  logic              rdy_dn
);

    localparam int NST = Q_W + 1;

    logic              v_reg    [0:NST-1];
    side_t             side_reg [0:NST-1];
    logic [ROOT_W-1:0] mag_reg  [0:NST-1];
    logic [DN_W-1:0]   remx_reg [0:NST-1];
    logic [DN_W-1:0]   remy_reg [0:NST-1];
    logic [Q_W-1:0]    qx_reg   [0:NST-1];
    logic [Q_W-1:0]    qy_reg   [0:NST-1];
    logic [NST:0]      en;

    assign en[NST] = rdy_dn;
    assign in_rdy  = en[0];

    genvar k;
    generate
        for (k = 0; k < NST; k++)
        begin : g_stage
            logic [DN_W-1:0] remx_next, remy_next;
            logic [Q_W-1:0]  qx_next, qy_next;
            logic            p_v;
            side_t           p_side;
            logic [ROOT_W-1:0] p_mag;

            if (k == 0)
            begin : g_first
                // numerator |c| * 32768 + mag for round half up
                assign p_v       = in_vld;
                assign p_side    = in_side;
                assign p_mag     = in_mag;
                assign remx_next = (DN_W'(in_vx) << Q_W) + DN_W'(in_mag);
                assign remy_next = (DN_W'(in_vy) << Q_W) + DN_W'(in_mag);
                assign qx_next   = '0;
                assign qy_next   = '0;
            end
            else
            begin : g_next
                logic [DN_W-1:0] den_sh;
                logic            gex, gey;

                assign p_v    = v_reg[k-1];
                assign p_side = side_reg[k-1];
                assign p_mag  = mag_reg[k-1];
                assign den_sh = DN_W'({mag_reg[k-1], 1'b0}) << (Q_W - k);
                assign gex    = remx_reg[k-1] >= den_sh;
                assign gey    = remy_reg[k-1] >= den_sh;
                assign remx_next = gex ? (remx_reg[k-1] - den_sh) : remx_reg[k-1];
                assign remy_next = gey ? (remy_reg[k-1] - den_sh) : remy_reg[k-1];
                assign qx_next   = qx_reg[k-1] | (Q_W'(gex) << (Q_W - k));
                assign qy_next   = qy_reg[k-1] | (Q_W'(gey) << (Q_W - k));
            end

            assign en[k] = !v_reg[k] || en[k+1];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[k] <= 1'b0;
                else if (en[k])
                    v_reg[k] <= p_v;
            end

            always_ff @(posedge clk)
            begin
                if (en[k])
                begin
                    side_reg[k] <= p_side;
                    mag_reg[k]  <= p_mag;
                    remx_reg[k] <= remx_next;
                    remy_reg[k] <= remy_next;
                    qx_reg[k]   <= qx_next;
                    qy_reg[k]   <= qy_next;
                end
            end
        end
    endgenerate

    assign vld  = v_reg[NST-1];
    assign side = side_reg[NST-1];
    assign mag  = mag_reg[NST-1];
    assign qx   = qx_reg[NST-1];
    assign qy   = qy_reg[NST-1];

endmodule

/* sv/circle_box_collision_test.sv */
// top level: 2d circle/box narrow-phase collision pipeline with output register
// stages from input beat to output beat: 6 geometry stages, 34 square root stages (one
// root bit each), 16 divide stages (one quotient bit each after the first), 1 output
// throughput one pair per cycle; each stage holds only while it is full and blocked
// reset clears the valid bit of every stage, the payload registers are not reset
module circle_box_collision_test import cbc_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               a_kind,
    input  logic [1:0]               b_kind,
    input  logic                     same_entity,
    input  logic signed [POS_W-1:0]  a_pos_x,
    input  logic signed [POS_W-1:0]  a_pos_y,
    input  logic signed [POS_W-1:0]  b_pos_x,
    input  logic signed [POS_W-1:0]  b_pos_y,
    input  logic [SIZE_W-1:0]        a_size_x,
    input  logic [SIZE_W-1:0]        a_size_y,
    input  logic [SIZE_W-1:0]        b_size_x,
    input  logic [SIZE_W-1:0]        b_size_y,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     hit,
    output logic                     swapped,
    output logic signed [NORM_W-1:0] normal_x,
    output logic signed [NORM_W-1:0] normal_y,
    output logic signed [PEN_W-1:0]  pen_dist
);

    logic              f_vld, f_rdy_dn;
    side_t             f_side;
    logic [VEC_W-1:0]  f_vx, f_vy;
    logic [SUM_W-1:0]  f_sum;

    logic              r_vld, r_rdy_dn;
    side_t             r_side;
    logic [VEC_W-1:0]  r_vx, r_vy;
    logic [ROOT_W-1:0] r_mag;

    logic              d_vld, d_rdy_dn;
    side_t             d_side;
    logic [ROOT_W-1:0] d_mag;
    logic [Q_W-1:0]    d_qx, d_qy;

    logic              out_valid_reg;
    logic              hit_reg, swapped_reg;
    logic [NORM_W-1:0] nx_reg, ny_reg, nx_next, ny_next, qx16, qy16;
    logic [PEN_W-1:0]  pen_reg, pen_next;
    logic [PEN_W+4:0]  pen_wide;
    logic              mag_zero;

    cbc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .a_kind      (a_kind),
        .b_kind      (b_kind),
        .same_entity (same_entity),
        .a_pos_x     (a_pos_x),
        .a_pos_y     (a_pos_y),
        .b_pos_x     (b_pos_x),
        .b_pos_y     (b_pos_y),
        .a_size_x    (a_size_x),
        .a_size_y    (a_size_y),
        .b_size_x    (b_size_x),
        .b_size_y    (b_size_y),
        .vld         (f_vld),
        .side        (f_side),
        .vx          (f_vx),
        .vy          (f_vy),
        .sum         (f_sum),
        .rdy_dn      (f_rdy_dn)
    );

    cbc_sqrt u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (f_vld),
        .in_rdy  (f_rdy_dn),
        .in_side (f_side),
        .in_vx   (f_vx),
        .in_vy   (f_vy),
        .in_sum  (f_sum),
        .vld     (r_vld),
        .side    (r_side),
        .vx      (r_vx),
        .vy      (r_vy),
        .mag     (r_mag),
        .rdy_dn  (r_rdy_dn)
    );

    cbc_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (r_vld),
        .in_rdy  (r_rdy_dn),
        .in_side (r_side),
        .in_vx   (r_vx),
        .in_vy   (r_vy),
        .in_mag  (r_mag),
        .vld     (d_vld),
        .side    (d_side),
        .mag     (d_mag),
        .qx      (d_qx),
        .qy      (d_qy),
        .rdy_dn  (d_rdy_dn)
    );

    assign d_rdy_dn = !out_valid_reg || out_ready;
    assign mag_zero = (d_mag == '0);
    assign qx16     = {1'b0, d_qx};
    assign qy16     = {1'b0, d_qy};

    always_comb
    begin
        nx_next = '0;
        ny_next = '0;
        case (d_side.nsel)
            NS_POSX: nx_next = ONE_Q14;
            NS_NEGX: nx_next = NEG_ONE_Q14;
            NS_POSY: ny_next = ONE_Q14;
            NS_NEGY: ny_next = NEG_ONE_Q14;
            default:
            begin
                if (!mag_zero)
                begin
                    nx_next = d_side.sx ? (NORM_W'(0) - qx16) : qx16;
                    ny_next = d_side.sy ? (NORM_W'(0) - qy16) : qy16;
                end
            end
        endcase
    end

    // depth with saturation to the signed 32-bit range
    assign pen_wide = {4'b0000, d_side.rval} - {3'b000, d_mag};

    always_comb
    begin
        if ($signed(pen_wide) > $signed(37'sh0_7FFF_FFFF))
            pen_next = 32'h7FFF_FFFF;
        else if ($signed(pen_wide) < -$signed(37'sh0_8000_0000))
            pen_next = 32'h8000_0000;
        else
            pen_next = pen_wide[PEN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (d_rdy_dn)
            out_valid_reg <= d_vld;
    end

    always_ff @(posedge clk)
    begin
        if (d_rdy_dn)
        begin
            hit_reg     <= d_side.hit;
            swapped_reg <= d_side.hit && d_side.swapped;
            nx_reg      <= d_side.hit ? nx_next : '0;
            ny_reg      <= d_side.hit ? ny_next : '0;
            pen_reg     <= d_side.hit ? pen_next : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign swapped   = swapped_reg;
    assign normal_x  = nx_reg;
    assign normal_y  = ny_reg;
    assign pen_dist  = pen_reg;

    a_miss_zero : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> !swapped && normal_x == 0 && normal_y == 0 && pen_dist == 0)
        else $error("miss beat carries nonzero contact data");

    a_norm_range : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> normal_x <= 16'sd16384 && normal_x >= -16'sd16384 &&
                             normal_y <= 16'sd16384 && normal_y >= -16'sd16384)
        else $error("normal component outside unit range");

    a_full_stall : assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input blocked while output side is free");

endmodule
